// ----- sv/iebm_pkg.sv -----
// iebm_pkg: shared types, codes and the bit-sequence program for the i2c eeprom byte master
// used by iebm_if, iebm_front, iebm_back and i2c_eeprom_byte_master; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package iebm_pkg;

  // request classes after decode
  typedef enum logic [1:0] {
    CLS_TICK,
    CLS_WRITE,
    CLS_READ
  } cls_t;

  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_IDX_DEV_ADDR    = 2'd0;
  localparam logic [1:0] CFG_IDX_ACK_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_IDX_WRITE_WAIT  = 2'd2;

  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [5:0] STEP_IDLE = 6'd63;

  // per-tick operations of the sequencer
  typedef enum logic [3:0] {
    OP_SDA_HI,
    OP_SDA_LO,
    OP_SCL_HI,
    OP_SCL_LO,
    OP_BIT,
    OP_SCL_HI_BIT,
    OP_ACK_HI,
    OP_ACK_WAIT,
    OP_SAMPLE,
    OP_FIN_RD,
    OP_FIN_WR,
    OP_WWAIT
  } op_t;

  // byte source for a shifted-out byte
  typedef enum logic [1:0] {
    SRC_DEV_W,
    SRC_ADDR,
    SRC_DATA,
    SRC_DEV_R
  } src_t;

  typedef struct packed {
    op_t  op;
    src_t src;
  } tick_op_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] mem_addr;
    logic [7:0] write_value;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_value;
  } out_item_t;

  // queue entry between front and back
  typedef struct packed {
    cls_t       cls;
    logic [7:0] mem_addr;
    logic [7:0] write_value;
    logic       sda_in;
  } q_item_t;

  typedef struct packed {
    logic [6:0]  device_address;
    logic [7:0]  ack_timeout;
    logic [15:0] write_wait_ticks;
  } cfg_t;

  // program step lookup, write and read sequences
  function automatic tick_op_t prog_op(input logic rd, input logic [5:0] step);
    tick_op_t t;
    t = '{op: OP_WWAIT, src: SRC_DEV_W};
    if (!rd) begin
      case (step)
        6'd0:    t = '{op: OP_SDA_HI,     src: SRC_DEV_W};
        6'd1:    t = '{op: OP_SCL_HI,     src: SRC_DEV_W};
        6'd2:    t = '{op: OP_SDA_LO,     src: SRC_DEV_W};
        6'd3:    t = '{op: OP_SCL_LO,     src: SRC_DEV_W};
        6'd4:    t = '{op: OP_BIT,        src: SRC_DEV_W};
        6'd5:    t = '{op: OP_SCL_HI_BIT, src: SRC_DEV_W};
        6'd6:    t = '{op: OP_SCL_LO,     src: SRC_DEV_W};
        6'd7:    t = '{op: OP_SDA_HI,     src: SRC_DEV_W};
        6'd8:    t = '{op: OP_ACK_HI,     src: SRC_DEV_W};
        6'd9:    t = '{op: OP_ACK_WAIT,   src: SRC_DEV_W};
        6'd10:   t = '{op: OP_SCL_LO,     src: SRC_DEV_W};
        6'd11:   t = '{op: OP_BIT,        src: SRC_ADDR};
        6'd12:   t = '{op: OP_SCL_HI_BIT, src: SRC_DEV_W};
        6'd13:   t = '{op: OP_SCL_LO,     src: SRC_DEV_W};
        6'd14:   t = '{op: OP_SDA_HI,     src: SRC_DEV_W};
        6'd15:   t = '{op: OP_ACK_HI,     src: SRC_DEV_W};
        6'd16:   t = '{op: OP_ACK_WAIT,   src: SRC_DEV_W};
        6'd17:   t = '{op: OP_SCL_LO,     src: SRC_DEV_W};
        6'd18:   t = '{op: OP_BIT,        src: SRC_DATA};
        6'd19:   t = '{op: OP_SCL_HI_BIT, src: SRC_DEV_W};
        6'd20:   t = '{op: OP_SCL_LO,     src: SRC_DEV_W};
        6'd21:   t = '{op: OP_SDA_HI,     src: SRC_DEV_W};
        6'd22:   t = '{op: OP_ACK_HI,     src: SRC_DEV_W};
        6'd23:   t = '{op: OP_ACK_WAIT,   src: SRC_DEV_W};
        6'd24:   t = '{op: OP_SDA_LO,     src: SRC_DEV_W};
        6'd25:   t = '{op: OP_SCL_HI,     src: SRC_DEV_W};
        6'd26:   t = '{op: OP_FIN_WR,     src: SRC_DEV_W};
        default: t = '{op: OP_WWAIT,      src: SRC_DEV_W};
      endcase
    end else begin
      case (step)
        6'd0:    t = '{op: OP_SDA_HI,     src: SRC_DEV_W};
        6'd1:    t = '{op: OP_SCL_HI,     src: SRC_DEV_W};
        6'd2:    t = '{op: OP_SDA_LO,     src: SRC_DEV_W};
        6'd3:    t = '{op: OP_SCL_LO,     src: SRC_DEV_W};
        6'd4:    t = '{op: OP_BIT,        src: SRC_DEV_W};
        6'd5:    t = '{op: OP_SCL_HI_BIT, src: SRC_DEV_W};
        6'd6:    t = '{op: OP_SCL_LO,     src: SRC_DEV_W};
        6'd7:    t = '{op: OP_SDA_HI,     src: SRC_DEV_W};
        6'd8:    t = '{op: OP_ACK_HI,     src: SRC_DEV_W};
        6'd9:    t = '{op: OP_ACK_WAIT,   src: SRC_DEV_W};
        6'd10:   t = '{op: OP_SCL_LO,     src: SRC_DEV_W};
        6'd11:   t = '{op: OP_BIT,        src: SRC_ADDR};
        6'd12:   t = '{op: OP_SCL_HI_BIT, src: SRC_DEV_W};
        6'd13:   t = '{op: OP_SCL_LO,     src: SRC_DEV_W};
        6'd14:   t = '{op: OP_SDA_HI,     src: SRC_DEV_W};
        6'd15:   t = '{op: OP_ACK_HI,     src: SRC_DEV_W};
        6'd16:   t = '{op: OP_ACK_WAIT,   src: SRC_DEV_W};
        6'd17:   t = '{op: OP_SDA_HI,     src: SRC_DEV_W};
        6'd18:   t = '{op: OP_SCL_HI,     src: SRC_DEV_W};
        6'd19:   t = '{op: OP_SDA_LO,     src: SRC_DEV_W};
        6'd20:   t = '{op: OP_SCL_LO,     src: SRC_DEV_W};
        6'd21:   t = '{op: OP_BIT,        src: SRC_DEV_R};
        6'd22:   t = '{op: OP_SCL_HI_BIT, src: SRC_DEV_W};
        6'd23:   t = '{op: OP_SCL_LO,     src: SRC_DEV_W};
        6'd24:   t = '{op: OP_SDA_HI,     src: SRC_DEV_W};
        6'd25:   t = '{op: OP_ACK_HI,     src: SRC_DEV_W};
        6'd26:   t = '{op: OP_ACK_WAIT,   src: SRC_DEV_W};
        6'd27:   t = '{op: OP_SCL_LO,     src: SRC_DEV_W};
        6'd28:   t = '{op: OP_SDA_HI,     src: SRC_DEV_W};
        6'd29:   t = '{op: OP_SCL_HI,     src: SRC_DEV_W};
        6'd30:   t = '{op: OP_SAMPLE,     src: SRC_DEV_W};
        6'd31:   t = '{op: OP_SDA_LO,     src: SRC_DEV_W};
        6'd32:   t = '{op: OP_SCL_HI,     src: SRC_DEV_W};
        default: t = '{op: OP_FIN_RD,     src: SRC_DEV_W};
      endcase
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ----- sv/iebm_if.sv -----
// iebm_in_if and iebm_out_if: valid/ready channels for requests and results
// depends on iebm_pkg for the payload types
`timescale 1ns / 1ps
`default_nettype none

interface iebm_in_if import iebm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface iebm_out_if import iebm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- sv/i2c_eeprom_byte_master.sv -----
// i2c_eeprom_byte_master: top level, configuration registers and the front/back split
// depends on iebm_pkg, iebm_if, iebm_front and iebm_back
`timescale 1ns / 1ps
`default_nettype none

// bit-level i2c master for single-byte eeprom random writes and reads. every request is
// one half-bit tick (mode 0) or a command (mode 1 write, mode 2 read) that also counts as
// a tick; each request gives exactly one result with the scl/sda drive levels after that
// tick, a busy flag, a done pulse and the byte read. a command that arrives while a
// sequence or the post-write wait is still running is treated as a plain tick. the slave
// acknowledge is polled on sda_in for up to ack_timeout extra ticks and never flagged.
// rate: one request per clock while out_chan is ready; each request passes the
// queue and then the sequencer step that loads the result register which offers it.
// the request side only stalls when the two-entry queue is full, which happens only while
// the result side holds back. configuration writes are taken any cycle but must only be
// issued while no request is in flight.
module i2c_eeprom_byte_master import iebm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  iebm_in_if.sink                    in_chan,
  iebm_out_if.source                 out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t    cfg_r;
  q_item_t q_item;
  logic    q_valid;
  logic    q_pop;

  // configuration registers, out-of-range index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.device_address   <= 7'd80;
      cfg_r.ack_timeout      <= 8'd50;
      cfg_r.write_wait_ticks <= 16'd200;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IDX_DEV_ADDR:    cfg_r.device_address   <= cfg_wdata[6:0];
        CFG_IDX_ACK_TIMEOUT: cfg_r.ack_timeout      <= cfg_wdata[7:0];
        CFG_IDX_WRITE_WAIT:  cfg_r.write_wait_ticks <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // front: accept and classify requests into the queue
  iebm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  // back: one sequencer step per queued request, result register towards the sink
  iebm_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

  // a completing result never also reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> !(out_chan.payload.done_res && out_chan.payload.busy_res))
    else $error("done and busy together");

  // read byte only shows on a done result
  a_rv_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.payload.done_res) |-> (out_chan.payload.read_value == 8'd0))
    else $error("read value outside done");

  // request side stalls only while the queue holds work for the back end
  a_stall_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> q_valid)
    else $error("stall with empty queue");

  // the queue drains whenever the result register is free
  a_drain_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !out_chan.valid) |-> q_pop)
    else $error("queue not drained");

endmodule

`default_nettype wire

// ----- sv/iebm_front.sv -----
// iebm_front: takes requests, decodes mode into a class and holds them in a two-entry queue
// depends on iebm_pkg and iebm_in_if
`timescale 1ns / 1ps
`default_nettype none

module iebm_front import iebm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  iebm_in_if.sink   in_chan,
  output q_item_t   q_item,
  output logic      q_valid,
  input  wire logic q_pop
);

  q_item_t    entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       push;
  q_item_t    dec_item;

  assign in_chan.ready = (count_r != 2'd2);
  assign push          = in_chan.valid && in_chan.ready;
  assign q_valid       = (count_r != 2'd0);
  assign q_item        = entry_r[rd_ptr_r];

  // mode three falls back to a plain tick
  always_comb begin
    dec_item.mem_addr    = in_chan.payload.mem_addr;
    dec_item.write_value = in_chan.payload.write_value;
    dec_item.sda_in      = in_chan.payload.sda_in;
    case (in_chan.payload.mode)
      MODE_WRITE: dec_item.cls = CLS_WRITE;
      MODE_READ:  dec_item.cls = CLS_READ;
      default:    dec_item.cls = CLS_TICK;
    endcase
  end

  always_comb begin
    count_nxt = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= dec_item;
    end
  end

endmodule

`default_nettype wire

// ----- sv/iebm_back.sv -----
// iebm_back: bit-level sequencer that runs one queued request per cycle unless the sink holds
// back a result, plus the result register; depends on iebm_pkg and iebm_out_if
`timescale 1ns / 1ps
`default_nettype none

module iebm_back import iebm_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire cfg_t    cfg,
  input  wire q_item_t q_item,
  input  wire logic    q_valid,
  output logic         q_pop,
  iebm_out_if.source   out_chan
);

  logic [5:0]  step_r, step_nxt;
  logic [2:0]  bidx_r, bidx_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [15:0] wait_r, wait_nxt;
  logic        is_read_r, is_read_nxt;
  logic [7:0]  addr_r, addr_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        done;
  logic [7:0]  rd_val;
  logic        start;
  tick_op_t    top;
  logic [7:0]  src_byte;

  logic        out_valid_r;
  out_item_t   out_item_r;

  assign q_pop = q_valid && (!out_valid_r || out_chan.ready);
  assign start = (step_r == STEP_IDLE) && (q_item.cls == CLS_WRITE || q_item.cls == CLS_READ);

  always_comb begin
    step_nxt    = step_r;
    bidx_nxt    = bidx_r;
    shift_nxt   = shift_r;
    wait_nxt    = wait_r;
    is_read_nxt = is_read_r;
    addr_nxt    = addr_r;
    data_nxt    = data_r;
    scl_nxt     = scl_r;
    sda_nxt     = sda_r;
    done        = 1'b0;
    rd_val      = 8'd0;
    src_byte    = 8'd0;

    // a command taken while idle starts its first step on the same tick
    if (start) begin
      is_read_nxt = (q_item.cls == CLS_READ);
      addr_nxt    = q_item.mem_addr;
      data_nxt    = q_item.write_value;
      bidx_nxt    = 3'd0;
      shift_nxt   = 8'd0;
      wait_nxt    = 16'd0;
      step_nxt    = 6'd0;
    end

    top = prog_op(is_read_nxt, step_nxt);

    case (top.src)
      SRC_DEV_W: src_byte = {cfg.device_address, 1'b0};
      SRC_ADDR:  src_byte = addr_nxt;
      SRC_DATA:  src_byte = data_nxt;
      default:   src_byte = {cfg.device_address, 1'b1};
    endcase

    if (step_nxt != STEP_IDLE) begin
      case (top.op)
        OP_SDA_HI: begin
          sda_nxt  = 1'b1;
          step_nxt = step_nxt + 6'd1;
        end
        OP_SDA_LO: begin
          sda_nxt  = 1'b0;
          step_nxt = step_nxt + 6'd1;
        end
        OP_SCL_HI: begin
          scl_nxt  = 1'b1;
          step_nxt = step_nxt + 6'd1;
        end
        OP_SCL_LO: begin
          scl_nxt  = 1'b0;
          step_nxt = step_nxt + 6'd1;
        end
        OP_BIT: begin
          sda_nxt  = src_byte[3'd7 - bidx_nxt];
          step_nxt = step_nxt + 6'd1;
        end
        OP_SCL_HI_BIT: begin
          scl_nxt = 1'b1;
          if (bidx_nxt != 3'd7) begin
            bidx_nxt = bidx_nxt + 3'd1;
            step_nxt = step_nxt - 6'd2;
          end else begin
            bidx_nxt = 3'd0;
            step_nxt = step_nxt + 6'd1;
          end
        end
        OP_ACK_HI: begin
          scl_nxt  = 1'b1;
          wait_nxt = 16'd0;
          step_nxt = step_nxt + 6'd1;
        end
        OP_ACK_WAIT: begin
          if (q_item.sda_in && (wait_nxt < {8'd0, cfg.ack_timeout})) begin
            wait_nxt = wait_nxt + 16'd1;
          end else begin
            scl_nxt  = 1'b0;
            step_nxt = step_nxt + 6'd1;
          end
        end
        OP_SAMPLE: begin
          shift_nxt = {shift_nxt[6:0], q_item.sda_in};
          scl_nxt   = 1'b0;
          if (bidx_nxt != 3'd7) begin
            bidx_nxt = bidx_nxt + 3'd1;
            step_nxt = step_nxt - 6'd1;
          end else begin
            bidx_nxt = 3'd0;
            step_nxt = step_nxt + 6'd1;
          end
        end
        OP_FIN_RD: begin
          sda_nxt  = 1'b1;
          done     = 1'b1;
          rd_val   = shift_nxt;
          step_nxt = STEP_IDLE;
        end
        OP_FIN_WR: begin
          sda_nxt  = 1'b1;
          wait_nxt = cfg.write_wait_ticks;
          step_nxt = step_nxt + 6'd1;
        end
        default: begin
          if (wait_nxt == 16'd0) begin
            done     = 1'b1;
            step_nxt = STEP_IDLE;
          end else begin
            wait_nxt = wait_nxt - 16'd1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= STEP_IDLE;
      bidx_r    <= 3'd0;
      shift_r   <= 8'd0;
      wait_r    <= 16'd0;
      is_read_r <= 1'b0;
      addr_r    <= 8'd0;
      data_r    <= 8'd0;
      scl_r     <= 1'b1;
      sda_r     <= 1'b1;
    end else if (q_pop) begin
      step_r    <= step_nxt;
      bidx_r    <= bidx_nxt;
      shift_r   <= shift_nxt;
      wait_r    <= wait_nxt;
      is_read_r <= is_read_nxt;
      addr_r    <= addr_nxt;
      data_r    <= data_nxt;
      scl_r     <= scl_nxt;
      sda_r     <= sda_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_item_r.scl_out    <= scl_nxt;
      out_item_r.sda_out    <= sda_nxt;
      out_item_r.busy_res   <= (step_nxt != STEP_IDLE);
      out_item_r.done_res   <= done;
      out_item_r.read_value <= rd_val;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.payload = out_item_r;

endmodule

`default_nettype wire
